// ===== rtl/vfd_pkg.sv =====
// Shared types and constants of the varint frame deframer.
package vfd_pkg;

	// Varint decoder limits
	localparam int MAX_VARINT_BYTES = 5;
	localparam int VB_W = $clog2(MAX_VARINT_BYTES);

	// Field widths
	localparam int BYTE_W = 8;
	localparam int FLEN_W = 22;
	localparam int ACC_W = 32;
	localparam int ULEN_W = 31;
	localparam int ERR_W = 2;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = FLEN_W;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSION_ON = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LENGTH = CFG_IDX_W'(1);
	localparam logic [FLEN_W-1:0] MAX_FRAME_LENGTH_RST = FLEN_W'(22'h200000);

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
	localparam logic [ERR_W-1:0] ERR_VARINT_LONG = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FRAME_LEN = 2'd2;
	localparam logic [ERR_W-1:0] ERR_TRUNCATED = 2'd3;

	// One result word
	typedef struct packed {
		logic [BYTE_W-1:0]       payload_byte;
		logic                    byte_valid;
		logic signed [ACC_W-1:0] packet_id;
		logic                    compressed;
		logic [ULEN_W-1:0]       uncompressed_length;
		logic                    frame_end;
		logic [ERR_W-1:0]        err_code;
	} vfd_res_t;

endpackage

// ===== rtl/vfd_in_if.sv =====
// Received byte channel.
interface vfd_in_if;
	import vfd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/vfd_out_if.sv =====
// Result channel: payload bytes, frame ends and errors.
interface vfd_out_if;
	import vfd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [BYTE_W-1:0]       payload_byte;
	logic                    byte_valid;
	logic signed [ACC_W-1:0] packet_id;
	logic                    compressed;
	logic [ULEN_W-1:0]       uncompressed_length;
	logic                    frame_end;
	logic [ERR_W-1:0]        err_code;

	modport source (output valid, output payload_byte, output byte_valid, output packet_id,
		output compressed, output uncompressed_length, output frame_end,
		output err_code, input ready);
	modport sink (input valid, input payload_byte, input byte_valid, input packet_id,
		input compressed, input uncompressed_length, input frame_end,
		input err_code, output ready);
endinterface

// ===== rtl/vfd_cfg_if.sv =====
// Configuration write channel.
interface vfd_cfg_if;
	import vfd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] value;

	modport source (output valid, output index, output value, input ready);
	modport sink (input valid, input index, input value, output ready);
endinterface

// ===== rtl/varint_frame_deframer_core.sv =====
// Varint length-prefixed frame deframer: top level.
//
// Usage:
//  data   : one received (decrypted) byte per word, valid/ready.
//  result : payload bytes, frame-end markers and error reports, valid/ready.
//  cfg    : register writes (0 compression_on, 1 max_frame_length); always ready,
//           write only while the block is idle. Unknown indexes are ignored.
// Each frame is a varint frame length, then (compression on) a data-length
// varint, then a packet id varint and payload, or a raw compressed body.
// A byte accepted into the input register is decoded from there, and its result,
// if any, is loaded into the result register. Throughput: one byte per cycle
// while no result waits on result.ready, set by the state update between the two registers.
// Bytes that produce no result (varint bytes) still pass through the input register.
// Reset: frame-length phase, compression off, max frame length 0x200000,
// no result pending. After any error no more results come until reset.
// Stall: while a result waits on result.ready, the input register holds one
// byte and data.ready drops once it is full; nothing is lost.
module varint_frame_deframer_core (
	input logic        clk,
	input logic        arst_n,
	vfd_in_if.sink     data,
	vfd_out_if.source  result,
	vfd_cfg_if.sink    cfg
);
	import vfd_pkg::*;

	localparam logic [2:0] PH_LEN     = 3'd0;
	localparam logic [2:0] PH_DLEN    = 3'd1;
	localparam logic [2:0] PH_PID     = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_RAW     = 3'd4;

	// Input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;
	// Configuration
	logic              compression_on_q;
	logic [FLEN_W-1:0] max_frame_length_q;
	// Frame state
	logic [2:0]        phase_q, phase_n;
	logic [ACC_W-1:0]  accum_q, accum_n;
	logic [VB_W-1:0]   vbytes_q, vbytes_n;
	logic [FLEN_W-1:0] bytes_left_q, bytes_left_n;
	logic [ACC_W-1:0]  current_id_q, current_id_n;
	logic [ULEN_W-1:0] data_length_q, data_length_n;
	logic              dead_q, dead_n;
	// Result stage
	logic              valid_s2;
	vfd_res_t          res_s2;

	logic              adv;
	logic              res_gen;
	vfd_res_t          res;
	logic [63:0]       grp_ext;
	logic [ACC_W-1:0]  feed_accum;
	logic              feed_done;
	logic              feed_long;
	logic              last;

	// Handshakes
	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign data.ready = !valid_s1 || adv;
	assign cfg.ready  = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.valid && data.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data.valid && data.ready) begin
			rx_byte_s1 <= data.rx_byte;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compression_on_q   <= 1'b0;
			max_frame_length_q <= MAX_FRAME_LENGTH_RST;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == CFG_COMPRESSION_ON) begin
				compression_on_q <= cfg.value[0];
			end else if (cfg.index == CFG_MAX_FRAME_LENGTH) begin
				max_frame_length_q <= cfg.value[FLEN_W-1:0];
			end
		end
	end

	// Byte decode and next state
	always_comb begin
		grp_ext    = {57'd0, rx_byte_s1[6:0]};
		feed_accum = accum_q | ACC_W'(grp_ext << (7 * vbytes_q));
		feed_done  = !rx_byte_s1[7];
		feed_long  = rx_byte_s1[7] && (vbytes_q == VB_W'(MAX_VARINT_BYTES - 1));
		last       = bytes_left_q <= FLEN_W'(1);

		phase_n       = phase_q;
		accum_n       = accum_q;
		vbytes_n      = vbytes_q;
		bytes_left_n  = bytes_left_q;
		current_id_n  = current_id_q;
		data_length_n = data_length_q;
		dead_n        = dead_q;
		res_gen       = 1'b0;
		res           = '0;

		if (!dead_q) begin
			unique case (phase_q)
				PH_LEN: begin
					if (feed_long) begin
						dead_n = 1'b1;
						res_gen = 1'b1;
						res.err_code = ERR_VARINT_LONG;
					end else if (!feed_done) begin
						accum_n  = feed_accum;
						vbytes_n = vbytes_q + VB_W'(1);
					end else if (feed_accum == '0 ||
						feed_accum > {{(ACC_W-FLEN_W){1'b0}}, max_frame_length_q}) begin
						dead_n = 1'b1;
						res_gen = 1'b1;
						res.err_code = ERR_FRAME_LEN;
					end else begin
						bytes_left_n = feed_accum[FLEN_W-1:0];
						accum_n  = '0;
						vbytes_n = '0;
						phase_n  = compression_on_q ? PH_DLEN : PH_PID;
					end
				end
				PH_DLEN, PH_PID: begin
					bytes_left_n = bytes_left_q - FLEN_W'(bytes_left_q != '0);
					if (feed_long) begin
						dead_n = 1'b1;
						res_gen = 1'b1;
						res.err_code = ERR_VARINT_LONG;
					end else if (!feed_done) begin
						if (last) begin
							dead_n = 1'b1;
							res_gen = 1'b1;
							res.err_code = ERR_TRUNCATED;
						end else begin
							accum_n  = feed_accum;
							vbytes_n = vbytes_q + VB_W'(1);
						end
					end else begin
						accum_n  = '0;
						vbytes_n = '0;
						if (phase_q == PH_DLEN) begin
							if (feed_accum == '0) begin
								// zero data length: packet id must follow
								if (last) begin
									dead_n = 1'b1;
									res_gen = 1'b1;
									res.err_code = ERR_TRUNCATED;
								end else begin
									phase_n = PH_PID;
								end
							end else begin
								data_length_n = feed_accum[ULEN_W-1:0];
								if (last) begin
									// compressed frame with empty raw body
									phase_n = PH_LEN;
									res_gen = 1'b1;
									res.compressed = 1'b1;
									res.uncompressed_length = feed_accum[ULEN_W-1:0];
									res.frame_end = 1'b1;
								end else begin
									phase_n = PH_RAW;
								end
							end
						end else begin
							current_id_n = feed_accum;
							if (last) begin
								phase_n = PH_LEN;
								res_gen = 1'b1;
								res.packet_id = feed_accum;
								res.frame_end = 1'b1;
							end else begin
								phase_n = PH_PAYLOAD;
							end
						end
					end
				end
				PH_RAW: begin
					bytes_left_n = bytes_left_q - FLEN_W'(bytes_left_q != '0);
					res_gen = 1'b1;
					res.payload_byte = rx_byte_s1;
					res.byte_valid = 1'b1;
					res.compressed = 1'b1;
					res.uncompressed_length = data_length_q;
					res.frame_end = last;
					if (last) begin
						phase_n = PH_LEN;
					end
				end
				PH_PAYLOAD: begin
					bytes_left_n = bytes_left_q - FLEN_W'(bytes_left_q != '0);
					res_gen = 1'b1;
					res.payload_byte = rx_byte_s1;
					res.byte_valid = 1'b1;
					res.packet_id = current_id_q;
					res.frame_end = last;
					if (last) begin
						phase_n = PH_LEN;
					end
				end
				default: begin
					phase_n = PH_LEN;
				end
			endcase
		end
	end

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LEN;
			accum_q       <= '0;
			vbytes_q      <= '0;
			bytes_left_q  <= '0;
			current_id_q  <= '0;
			data_length_q <= '0;
			dead_q        <= 1'b0;
		end else if (adv) begin
			phase_q       <= phase_n;
			accum_q       <= accum_n;
			vbytes_q      <= vbytes_n;
			bytes_left_q  <= bytes_left_n;
			current_id_q  <= current_id_n;
			data_length_q <= data_length_n;
			dead_q        <= dead_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv && res_gen) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_gen) begin
			res_s2 <= res;
		end
	end

	assign result.valid               = valid_s2;
	assign result.payload_byte        = res_s2.payload_byte;
	assign result.byte_valid          = res_s2.byte_valid;
	assign result.packet_id           = res_s2.packet_id;
	assign result.compressed          = res_s2.compressed;
	assign result.uncompressed_length = res_s2.uncompressed_length;
	assign result.frame_end           = res_s2.frame_end;
	assign result.err_code            = res_s2.err_code;

	// Checks
	a_dead_silent: assert property (@(posedge clk) disable iff (!arst_n)
		dead_q && !valid_s2 |=> !valid_s2)
		else $error("result produced after error");

	a_err_kills: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_gen && res.err_code != ERR_NONE |=> dead_q)
		else $error("error reported without going dead");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.err_code != ERR_NONE |->
		!res_s2.byte_valid && !res_s2.frame_end && res_s2.payload_byte == '0)
		else $error("error result carries data");

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_LEN && !dead_q |-> bytes_left_q != '0)
		else $error("body phase with no bytes left");

	a_vbytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		vbytes_q < VB_W'(MAX_VARINT_BYTES))
		else $error("varint byte count out of range");

endmodule
